@@ src/nearest_palette_color_quantizer_assert.svh @@
`ifndef NEAREST_PALETTE_COLOR_QUANTIZER_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_QUANTIZER_ASSERT_SVH

// Implication checked outside of reset.
`define NPCQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("npcq assertion failed");

// Next-cycle implication that is also checked while reset is applied.
`define NPCQ_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("npcq assertion failed");

`endif

@@ src/npcq_pkg.sv @@
package npcq_pkg;

    localparam int PAL_ENTRIES = 4;
    localparam int IDX_W       = $clog2(PAL_ENTRIES);
    localparam int CFG_IDX_W   = IDX_W + 1;
    localparam int COLOR_W     = 24;
    localparam int SUM_W       = 20;
    localparam int TERM_W      = 18;
    localparam int SQ_W        = 16;
    localparam int WEIGHT_W    = 10;
    localparam int PROD_W      = 26;
    localparam int CELL_STAGES = 3;
    localparam int LATENCY     = CELL_STAGES * PAL_ENTRIES;

    localparam logic [COLOR_W-1:0] PAL_RESET [8] = '{
        24'h000000, 24'h55FFFF, 24'hFF55FF, 24'hFFFFFF,
        24'h000000, 24'h000000, 24'h000000, 24'h000000
    };

    localparam logic [WEIGHT_W-1:0] RED_BASE  = 10'd512;
    localparam logic [WEIGHT_W-1:0] BLUE_BASE = 10'd767;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
    } t_pixel;

    typedef struct packed {
        logic [1:0] best_index;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_result;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [COLOR_W-1:0]   data;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [SUM_W-1:0]   sum;
        logic [COLOR_W-1:0] color;
    } t_best;

    typedef struct packed {
        logic   valid;
        t_pixel pix;
        t_best  best;
    } t_link;

    function automatic logic [COLOR_W-1:0] pal_reset(input logic [IDX_W-1:0] k);
        return PAL_RESET[3'(k)];
    endfunction

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ src/nearest_palette_color_quantizer.sv @@
// Nearest palette color quantizer using the redmean color distance.
// Input channel: a pixel word on i_pixel is taken at each rising edge where
// start is high and busy is low. The block is always ready, so busy stays low
// and a new word may be given in every cycle.
// Output channel: o_valid is high for exactly one cycle with the result word
// on o_result, holding the index and color of the nearest palette entry.
// The receiver cannot stall, and none is needed since results leave in order.
// Words pass through the chain of cells, each of which squares, weights and
// compares in three register stages. Throughput is one word per cycle.
// Palette entries are written through i_cfg_we, i_cfg_idx and i_cfg_data;
// the user must write them only while no word is in flight, which the block
// itself does not enforce. An index beyond the palette is ignored.
// Synchronous reset clears the pipeline and restores the default palette of
// black, cyan, magenta and white.
module nearest_palette_color_quantizer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  npcq_pkg::t_pixel                 i_pixel,
    output logic                             o_valid,
    output npcq_pkg::t_result                o_result,
    input  logic                             i_cfg_we,
    input  logic [npcq_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [npcq_pkg::COLOR_W-1:0]     i_cfg_data
);

    npcq_pkg::t_link link [npcq_pkg::PAL_ENTRIES+1];
    npcq_pkg::t_cfg  cfg;

    assign busy = 1'b0;

    always_comb begin
        cfg.we   = i_cfg_we;
        cfg.idx  = i_cfg_idx;
        cfg.data = i_cfg_data;

        link[0].valid      = start && !busy;
        link[0].pix        = i_pixel;
        link[0].best.idx   = '0;
        link[0].best.sum   = '1;
        link[0].best.color = '0;
    end

    for (genvar k = 0; k < npcq_pkg::PAL_ENTRIES; k++) begin : g_cell
        npcq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (npcq_pkg::IDX_W'(k)),
            .i_cfg   (cfg),
            .i_link  (link[k]),
            .o_link  (link[k+1])
        );
    end

    always_comb begin
        o_valid             = link[npcq_pkg::PAL_ENTRIES].valid;
        o_result.best_index = 2'(link[npcq_pkg::PAL_ENTRIES].best.idx);
        o_result.out_red    = link[npcq_pkg::PAL_ENTRIES].best.color[23:16];
        o_result.out_green  = link[npcq_pkg::PAL_ENTRIES].best.color[15:8];
        o_result.out_blue   = link[npcq_pkg::PAL_ENTRIES].best.color[7:0];
    end

endmodule

@@ src/npcq_cell.sv @@
module npcq_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [npcq_pkg::IDX_W-1:0]   i_idx,
    input  npcq_pkg::t_cfg               i_cfg,
    input  npcq_pkg::t_link              i_link,
    output npcq_pkg::t_link              o_link
);

    logic [npcq_pkg::COLOR_W-1:0]  r_pal;

    logic                          r_s1_valid;
    npcq_pkg::t_pixel              r_s1_pix;
    npcq_pkg::t_best               r_s1_best;
    logic [npcq_pkg::SQ_W-1:0]     r_s1_sq_r, r_s1_sq_g, r_s1_sq_b;
    logic [npcq_pkg::WEIGHT_W-1:0] r_s1_wr, r_s1_wb;

    logic                          r_s2_valid;
    npcq_pkg::t_pixel              r_s2_pix;
    npcq_pkg::t_best               r_s2_best;
    logic [npcq_pkg::TERM_W-1:0]   r_s2_rt, r_s2_gt, r_s2_bt;

    npcq_pkg::t_link               r_out;

    logic [7:0]                    dr, dg, db, mean;
    logic [npcq_pkg::PROD_W-1:0]   prod_r, prod_b;
    logic [npcq_pkg::SUM_W-1:0]    sum;
    npcq_pkg::t_best               n_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal <= npcq_pkg::pal_reset(i_idx);
        end else if (i_cfg.we && i_cfg.idx == npcq_pkg::CFG_IDX_W'(i_idx)) begin
            r_pal <= i_cfg.data;
        end
    end

    always_comb begin
        dr   = npcq_pkg::abs_diff(i_link.pix.pixel_red, r_pal[23:16]);
        dg   = npcq_pkg::abs_diff(i_link.pix.pixel_green, r_pal[15:8]);
        db   = npcq_pkg::abs_diff(i_link.pix.pixel_blue, r_pal[7:0]);
        mean = 8'(({1'b0, i_link.pix.pixel_red} + {1'b0, r_pal[23:16]}) >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_link.valid;
        end
        r_s1_pix  <= i_link.pix;
        r_s1_best <= i_link.best;
        r_s1_sq_r <= {8'd0, dr} * {8'd0, dr};
        r_s1_sq_g <= {8'd0, dg} * {8'd0, dg};
        r_s1_sq_b <= {8'd0, db} * {8'd0, db};
        r_s1_wr   <= npcq_pkg::RED_BASE + {2'd0, mean};
        r_s1_wb   <= npcq_pkg::BLUE_BASE - {2'd0, mean};
    end

    always_comb begin
        prod_r = {16'd0, r_s1_wr} * {10'd0, r_s1_sq_r};
        prod_b = {16'd0, r_s1_wb} * {10'd0, r_s1_sq_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_pix  <= r_s1_pix;
        r_s2_best <= r_s1_best;
        r_s2_rt   <= prod_r[25:8];
        r_s2_gt   <= {r_s1_sq_g, 2'b00};
        r_s2_bt   <= prod_b[25:8];
    end

    always_comb begin
        sum = {2'd0, r_s2_rt} + {2'd0, r_s2_gt} + {2'd0, r_s2_bt};
        if (sum < r_s2_best.sum) begin
            n_best.idx   = i_idx;
            n_best.sum   = sum;
            n_best.color = r_pal;
        end else begin
            n_best = r_s2_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out.valid <= r_s2_valid;
        end
        r_out.pix  <= r_s2_pix;
        r_out.best <= n_best;
    end

    assign o_link = r_out;

endmodule

@@ src/npcq_checker.sv @@
`include "nearest_palette_color_quantizer_assert.svh"

module npcq_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             o_valid
);

    // Every result word traces back to a word accepted a fixed latency earlier.
    `NPCQ_ASSERT_IMPLIES(a_result_has_source, i_clk, i_rst_n, o_valid, $past(start && !busy, npcq_pkg::LATENCY))

    // The block never refuses a word.
    `NPCQ_ASSERT_IMPLIES(a_always_ready, i_clk, i_rst_n, start, !busy)

    // Reset leaves no result word pending.
    `NPCQ_ASSERT_NEXT(a_reset_clears, i_clk, !i_rst_n, !o_valid)

endmodule

bind nearest_palette_color_quantizer npcq_checker u_npcq_checker (.*);

@@ bench/nearest_palette_color_quantizer_tb.sv @@
module nearest_palette_color_quantizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_GAP          = 11;
    localparam int RANDOM_PIXELS    = 1200;
    localparam int RANDOM_SETTINGS  = 12;
    localparam int SETTLE_CYCLES    = 2;
    localparam int MAX_REPORTS      = 40;
    localparam int unsigned RED_BIAS  = 512;
    localparam int unsigned BLUE_BIAS = 767;

    localparam logic [npcq_pkg::CFG_IDX_W-1:0] FIRST_UNUSED_IDX =
        npcq_pkg::CFG_IDX_W'(npcq_pkg::PAL_ENTRIES);
    localparam logic [npcq_pkg::CFG_IDX_W-1:0] LAST_CFG_IDX     = '1;

    localparam logic [npcq_pkg::COLOR_W-1:0] BLACK   = 24'h000000;
    localparam logic [npcq_pkg::COLOR_W-1:0] CYAN    = 24'h55FFFF;
    localparam logic [npcq_pkg::COLOR_W-1:0] MAGENTA = 24'hFF55FF;
    localparam logic [npcq_pkg::COLOR_W-1:0] WHITE   = 24'hFFFFFF;

    typedef struct {
        bit                             is_cfg;
        npcq_pkg::t_pixel               pix;
        logic [npcq_pkg::CFG_IDX_W-1:0] idx;
        logic [npcq_pkg::COLOR_W-1:0]   data;
    } t_job;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           start      = 1'b0;
    logic                           busy;
    npcq_pkg::t_pixel               i_pixel    = '0;
    logic                           o_valid;
    npcq_pkg::t_result              o_result;
    logic                           i_cfg_we   = 1'b0;
    logic [npcq_pkg::CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [npcq_pkg::COLOR_W-1:0]   i_cfg_data = '0;

    t_job                         pending_jobs[$];
    npcq_pkg::t_result            expected_results[$];
    logic [npcq_pkg::COLOR_W-1:0] palette_model [npcq_pkg::PAL_ENTRIES];
    logic [npcq_pkg::COLOR_W-1:0] plan_palette  [npcq_pkg::PAL_ENTRIES];

    int n_sent      = 0;
    int n_taken     = 0;
    int n_checked   = 0;
    int n_writes    = 0;
    int n_settings  = 0;
    int n_errors    = 0;
    int idle_cycles = 0;
    int gap_left    = 0;
    int burst_left  = 0;

    nearest_palette_color_quantizer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_pixel    (i_pixel),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Timeout: %0d pixel words still pending, %0d results outstanding.",
                 pending_jobs.size(), expected_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
    endtask

    function automatic int unsigned redmean_cost(input logic [npcq_pkg::COLOR_W-1:0] color,
                                                 input npcq_pkg::t_pixel pix);
        int unsigned pr, pg, pb, mean, dr, dg, db;
        pr   = color[23:16];
        pg   = color[15:8];
        pb   = color[7:0];
        dr   = (pr > pix.pixel_red)   ? pr - pix.pixel_red   : pix.pixel_red - pr;
        dg   = (pg > pix.pixel_green) ? pg - pix.pixel_green : pix.pixel_green - pg;
        db   = (pb > pix.pixel_blue)  ? pb - pix.pixel_blue  : pix.pixel_blue - pb;
        mean = (pr + pix.pixel_red) >> 1;
        return (((RED_BIAS + mean) * dr * dr) >> 8) + 4 * dg * dg
             + (((BLUE_BIAS - mean) * db * db) >> 8);
    endfunction

    function automatic npcq_pkg::t_result nearest_color(input npcq_pkg::t_pixel pix);
        npcq_pkg::t_result res;
        int unsigned       best_cost;
        int unsigned       cost;
        int                best;
        best      = 0;
        best_cost = redmean_cost(palette_model[0], pix);
        for (int k = 1; k < npcq_pkg::PAL_ENTRIES; k++) begin
            cost = redmean_cost(palette_model[k], pix);
            if (cost < best_cost) begin
                best_cost = cost;
                best      = k;
            end
        end
        res.best_index = 2'(best);
        res.out_red    = palette_model[best][23:16];
        res.out_green  = palette_model[best][15:8];
        res.out_blue   = palette_model[best][7:0];
        return res;
    endfunction

    function automatic int draw_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [7:0] near_level(input logic [7:0] level);
        int x;
        x = int'(level) + int'($urandom_range(0, 16)) - 8;
        if (x < 0) x = 0;
        if (x > 255) x = 255;
        return 8'(x);
    endfunction

    function automatic logic [7:0] extreme_level();
        case ($urandom_range(0, 2))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic npcq_pkg::t_pixel random_pixel();
        npcq_pkg::t_pixel             p;
        logic [npcq_pkg::COLOR_W-1:0] c;
        int                           pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            p = 24'($urandom);
        end else if (pick < 8) begin
            c = plan_palette[$urandom_range(0, npcq_pkg::PAL_ENTRIES - 1)];
            p.pixel_red   = near_level(c[23:16]);
            p.pixel_green = near_level(c[15:8]);
            p.pixel_blue  = near_level(c[7:0]);
        end else begin
            p.pixel_red   = extreme_level();
            p.pixel_green = extreme_level();
            p.pixel_blue  = extreme_level();
        end
        return p;
    endfunction

    task automatic push_pixel(input logic [npcq_pkg::COLOR_W-1:0] rgb);
        t_job job;
        job.is_cfg = 1'b0;
        job.pix    = rgb;
        job.idx    = '0;
        job.data   = '0;
        pending_jobs.push_back(job);
    endtask

    task automatic push_write(input logic [npcq_pkg::CFG_IDX_W-1:0] idx,
                              input logic [npcq_pkg::COLOR_W-1:0] data);
        t_job job;
        job.is_cfg = 1'b1;
        job.pix    = '0;
        job.idx    = idx;
        job.data   = data;
        pending_jobs.push_back(job);
    endtask

    task automatic push_palette(
        input logic [npcq_pkg::COLOR_W-1:0] colors [npcq_pkg::PAL_ENTRIES]);
        for (int k = 0; k < npcq_pkg::PAL_ENTRIES; k++) begin
            push_write(npcq_pkg::CFG_IDX_W'(k), colors[k]);
            plan_palette[k] = colors[k];
        end
        n_settings++;
    endtask

    // A pixel word is held on the bus until the edge that takes it; a palette write is
    // only issued once every result has come back.
    always @(negedge i_clk) begin : drive_words
        logic                           nxt_start;
        logic                           nxt_we;
        npcq_pkg::t_pixel               nxt_pix;
        logic [npcq_pkg::CFG_IDX_W-1:0] nxt_idx;
        logic [npcq_pkg::COLOR_W-1:0]   nxt_data;
        t_job                           job;
        nxt_start = start;
        nxt_pix   = i_pixel;
        nxt_we    = 1'b0;
        nxt_idx   = i_cfg_idx;
        nxt_data  = i_cfg_data;
        if (i_rst_n) begin
            if (start && n_taken == n_sent) begin
                nxt_start = 1'b0;
            end
            if (!nxt_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_jobs.size() > 0) begin
                    job = pending_jobs[0];
                    if (!job.is_cfg) begin
                        nxt_start = 1'b1;
                        nxt_pix   = job.pix;
                        n_sent++;
                        void'(pending_jobs.pop_front());
                        gap_left = draw_gap();
                    end else if (!start && expected_results.size() == 0
                                 && idle_cycles >= SETTLE_CYCLES) begin
                        nxt_we   = 1'b1;
                        nxt_idx  = job.idx;
                        nxt_data = job.data;
                        void'(pending_jobs.pop_front());
                        gap_left = draw_gap();
                    end
                end
            end
        end
        start      <= nxt_start;
        i_pixel    <= nxt_pix;
        i_cfg_we   <= nxt_we;
        i_cfg_idx  <= nxt_idx;
        i_cfg_data <= nxt_data;
    end

    always @(posedge i_clk) begin : watch_results
        npcq_pkg::t_result want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                n_writes++;
                if (i_cfg_idx < FIRST_UNUSED_IDX) begin
                    palette_model[i_cfg_idx[npcq_pkg::IDX_W-1:0]] = i_cfg_data;
                end
            end
            if (start && !busy) begin
                expected_results.push_back(nearest_color(i_pixel));
                n_taken++;
            end
            if ($isunknown(o_valid)) begin
                report_mismatch("o_valid is unknown");
            end else if (o_valid) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result word %h with nothing expected", o_result));
                end else begin
                    want = expected_results.pop_front();
                    n_checked++;
                    if (o_result.best_index !== want.best_index) begin
                        report_mismatch($sformatf("word %0d best_index %0d, expected %0d",
                                        n_checked, o_result.best_index, want.best_index));
                    end
                    if (o_result.out_red !== want.out_red) begin
                        report_mismatch($sformatf("word %0d out_red %h, expected %h",
                                        n_checked, o_result.out_red, want.out_red));
                    end
                    if (o_result.out_green !== want.out_green) begin
                        report_mismatch($sformatf("word %0d out_green %h, expected %h",
                                        n_checked, o_result.out_green, want.out_green));
                    end
                    if (o_result.out_blue !== want.out_blue) begin
                        report_mismatch($sformatf("word %0d out_blue %h, expected %h",
                                        n_checked, o_result.out_blue, want.out_blue));
                    end
                end
            end
            if (!start && expected_results.size() == 0) begin
                idle_cycles++;
            end else begin
                idle_cycles = 0;
            end
        end
    end

    initial begin : run_checks
        logic [npcq_pkg::COLOR_W-1:0] pal [npcq_pkg::PAL_ENTRIES];
        logic [npcq_pkg::COLOR_W-1:0] base;
        int                           style;
        int                           waited;

        palette_model[0] = BLACK;
        palette_model[1] = CYAN;
        palette_model[2] = MAGENTA;
        palette_model[3] = WHITE;
        plan_palette     = palette_model;

        push_pixel(24'h000000);
        push_pixel(24'hFFFFFF);
        push_pixel(CYAN);
        push_pixel(MAGENTA);
        push_pixel(24'h808080);
        push_pixel(24'hFF0000);
        push_pixel(24'h00FF00);
        push_pixel(24'h0000FF);

        pal = '{BLACK, BLACK, BLACK, BLACK};
        push_palette(pal);
        push_write(FIRST_UNUSED_IDX, WHITE);
        push_write(LAST_CFG_IDX, WHITE);
        push_pixel(24'hFFFFFF);
        push_pixel(24'h123456);

        pal = '{BLACK, 24'h000002, WHITE, WHITE};
        push_palette(pal);
        push_pixel(24'h000001);
        push_pixel(24'hFFFFFF);
        push_pixel(24'h000002);

        pal = '{WHITE, WHITE, WHITE, WHITE};
        push_palette(pal);
        push_pixel(24'h000000);
        push_pixel(24'hFFFFFF);

        pal = '{24'hFF0000, 24'h00FF00, 24'h0000FF, BLACK};
        push_palette(pal);
        push_pixel(24'h800000);
        push_pixel(24'h008000);
        push_pixel(24'h000080);

        for (int s = 0; s < RANDOM_SETTINGS; s++) begin
            style = $urandom_range(0, 3);
            base  = 24'($urandom);
            for (int k = 0; k < npcq_pkg::PAL_ENTRIES; k++) begin
                case (style)
                    0: pal[k] = 24'($urandom);
                    1: pal[k] = (k > 0 && $urandom_range(0, 1) == 1)
                                ? pal[$urandom_range(0, k - 1)] : 24'($urandom);
                    2: pal[k] = {($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00,
                                 ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00,
                                 ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00};
                    default: pal[k] = {near_level(base[23:16]), near_level(base[15:8]),
                                       near_level(base[7:0])};
                endcase
            end
            push_palette(pal);
            if ($urandom_range(0, 2) == 0) begin
                push_write(npcq_pkg::CFG_IDX_W'($urandom_range(npcq_pkg::PAL_ENTRIES,
                                                2 ** npcq_pkg::CFG_IDX_W - 1)),
                           24'($urandom));
            end
            for (int n = 0; n < RANDOM_PIXELS / RANDOM_SETTINGS; n++) begin
                push_pixel(random_pixel());
            end
        end

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_jobs.size() != 0 || start) @(posedge i_clk);
        waited = 0;
        while (expected_results.size() != 0 && waited < 4 * npcq_pkg::LATENCY + 16) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (npcq_pkg::LATENCY + 4) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end

        $display("Covered %0d pixel words and %0d results over %0d palette settings,",
                 n_taken, n_checked, n_settings);
        $display("with %0d register writes including out-of-range indexes; %0d mismatches.",
                 n_writes, n_errors);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
